// ===== rtl/ers_pkg.sv =====
// Shared types and constants for the enumeration rank sorter.
`timescale 1ns / 1ps
`default_nettype none

package ers_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [CNT_W-1:0]   count_t;

  // Chain-wide commands, at most one active per cycle
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ers_stream_if.sv =====
// Valid/ready stream interfaces for the sorter's input and output words.
`timescale 1ns / 1ps
`default_nettype none

interface ers_in_if
  import ers_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t value;
  logic  last_item;

  modport source(output valid, value, last_item, input ready);
  modport sink(input valid, value, last_item, output ready);
endinterface

interface ers_out_if
  import ers_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  end_of_set;

  modport source(output valid, sorted_value, end_of_set, input ready);
  modport sink(input valid, sorted_value, end_of_set, output ready);
endinterface

`default_nettype wire

// ===== rtl/ers_cell.sv =====
// One sorting cell: holds a value, inserts in order, shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none

module ers_cell
  import ers_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  word_t      new_value,
  input  word_t      left_value,
  input  logic       left_valid,
  input  logic       left_greater,
  input  word_t      right_value,
  input  logic       right_valid,
  output word_t      value,
  output logic       valid,
  output logic       greater
);

  logic take;

  assign greater = valid && (value > new_value);
  // Take a word where the held value is larger, or at the first empty slot
  assign take    = greater || (!valid && left_valid);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert && take) begin
      value <= left_greater ? left_value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && take) begin
      valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/enumeration_rank_sort.sv =====
// Streaming rank sorter: a chain of cells kept in ascending order.
// Input channel "items" carries one signed Q16.16 value per word; last_item
// closes the set. Each accepted word is inserted into a chain of MAX_ITEMS
// cells: every cell compares the word against its held value at once and
// larger values move one cell to the right, so equal values keep their
// arrival order. Up to MAX_ITEMS words are held; further words of the set
// are dropped, but a dropped last_item still closes the set.
// After the word with last_item, the block stops taking input and drains the
// chain through output channel "results", smallest first, one word per cycle
// from cell 0; end_of_set marks the final word. The first result is valid in
// the cycle after the closing word is accepted. A stalled receiver holds the
// head word and freezes the chain. Synchronous reset empties the chain and
// returns to taking input.
`timescale 1ns / 1ps
`default_nettype none

module enumeration_rank_sort
  import ers_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ers_in_if.sink     items,
  ers_out_if.source  results
);

  word_t                cell_value   [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_valid;
  logic [MAX_ITEMS-1:0] cell_greater;
  count_t               fill_count;
  logic                 draining;
  logic                 in_fire;
  logic                 out_fire;
  cell_ctrl_t           ctrl;

  assign items.ready = !draining;
  assign in_fire     = items.valid && items.ready;
  assign out_fire    = results.valid && results.ready;

  assign ctrl.insert = in_fire && (fill_count != count_t'(MAX_ITEMS));
  assign ctrl.shift  = out_fire;

  assign results.valid        = draining;
  assign results.sorted_value = cell_value[0];
  assign results.end_of_set   = (fill_count == count_t'(1));

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    word_t lv, rv;
    logic  lval, lgt, rval;
    if (i == 0) begin : g_head
      assign lv   = '0;
      assign lval = 1'b1;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lgt  = cell_greater[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_body
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    ers_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_value    (items.value),
      .left_value   (lv),
      .left_valid   (lval),
      .left_greater (lgt),
      .right_value  (rv),
      .right_valid  (rval),
      .value        (cell_value[i]),
      .valid        (cell_valid[i]),
      .greater      (cell_greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      draining   <= 1'b0;
    end else begin
      if (ctrl.insert) begin
        fill_count <= fill_count + count_t'(1);
      end else if (out_fire) begin
        fill_count <= fill_count - count_t'(1);
      end
      if (in_fire && items.last_item) begin
        draining <= 1'b1;
      end else if (out_fire && results.end_of_set) begin
        draining <= 1'b0;
      end
    end
  end

  // The held count always matches the number of occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(fill_count))
    else $error("fill count out of step with cell chain");

  // Draining never runs on an empty chain
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> (fill_count != '0) && cell_valid[0])
    else $error("draining with no held word");

  // The final word ends the drain and reopens the input
  a_end_releases: assert property (@(posedge clk) disable iff (rst)
    out_fire && results.end_of_set |=> !results.valid && items.ready
      && (fill_count == '0))
    else $error("drain did not finish after end of set");

  // The head cell holds a word no larger than the word in the next cell
  a_head_ordered: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> cell_value[0] <= cell_value[1])
    else $error("chain head out of order");

endmodule

`default_nettype wire
